// ===== design/aescbc_pkg.sv =====
package aescbc_pkg;

  localparam int NR = 10;

  typedef logic [7:0] byte_t;
  typedef byte_t tab_t [256];
  typedef byte_t rcon_t [NR + 1];

  typedef struct packed {
    logic dec;
    logic last;
  } lane_ctl_t;

  localparam logic [2:0] REG_KEY_UPPER = 3'd0;
  localparam logic [2:0] REG_KEY_LOWER = 3'd1;
  localparam logic [2:0] REG_IV_UPPER  = 3'd2;
  localparam logic [2:0] REG_IV_LOWER  = 3'd3;
  localparam logic [2:0] REG_DECRYPT   = 3'd4;

  function automatic byte_t xt(input byte_t b);
    return b[7] ? ({b[6:0], 1'b0} ^ 8'h1b) : {b[6:0], 1'b0};
  endfunction

  function automatic byte_t gmul(input byte_t a, input byte_t b);
    byte_t r;
    byte_t x;
    byte_t y;
    r = '0;
    x = a;
    y = b;
    for (int i = 0; i < 8; i++) begin
      if (x[0]) r = r ^ y;
      y = xt(y);
      x = x >> 1;
    end
    return r;
  endfunction

  function automatic byte_t rotl8(input byte_t b, input int n);
    return 8'((b << n) | (b >> (8 - n)));
  endfunction

  function automatic tab_t gen_sbox();
    tab_t t;
    byte_t v;
    for (int x = 0; x < 256; x++) begin
      v = '0;
      for (int y = 1; y < 256; y++) begin
        if (gmul(8'(x), 8'(y)) == 8'h01) v = 8'(y);
      end
      t[x] = v ^ rotl8(v, 1) ^ rotl8(v, 2) ^ rotl8(v, 3) ^ rotl8(v, 4) ^ 8'h63;
    end
    return t;
  endfunction

  localparam tab_t SBOX = gen_sbox();

  function automatic tab_t gen_rev_sub();
    tab_t t;
    for (int x = 0; x < 256; x++) t[SBOX[x]] = 8'(x);
    return t;
  endfunction

  localparam tab_t REV_SBOX = gen_rev_sub();

  localparam rcon_t RCON = '{8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                             8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

endpackage

// ===== design/aescbc_if.sv =====
interface aescbc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_upper;
  logic [63:0] block_lower;
  logic        first_block;

  modport source (output valid, block_upper, block_lower, first_block, input ready);
  modport sink (input valid, block_upper, block_lower, first_block, output ready);
endinterface

interface aescbc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_upper;
  logic [63:0] out_lower;

  modport source (output valid, out_upper, out_lower, input ready);
  modport sink (input valid, out_upper, out_lower, output ready);
endinterface

// ===== design/aescbc_lane.sv =====
module aescbc_lane (
  input  logic [31:0]          col,
  input  logic [31:0]          key,
  input  aescbc_pkg::lane_ctl_t ctl,
  output logic [31:0]          res
);

  aescbc_pkg::byte_t sb [4];
  aescbc_pkg::byte_t a [4];
  aescbc_pkg::byte_t m [4];
  logic [31:0] sbw;
  logic [31:0] aw;
  logic [31:0] mw;

  localparam aescbc_pkg::byte_t FWD [4] = '{8'h02, 8'h03, 8'h01, 8'h01};
  localparam aescbc_pkg::byte_t INV [4] = '{8'h0e, 8'h0b, 8'h0d, 8'h09};

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sb[r] = ctl.dec ? aescbc_pkg::REV_SBOX[col[31 - 8 * r -: 8]]
                      : aescbc_pkg::SBOX[col[31 - 8 * r -: 8]];
      sbw[31 - 8 * r -: 8] = sb[r];
    end
    aw = ctl.dec ? (sbw ^ key) : sbw;
    for (int r = 0; r < 4; r++) a[r] = aw[31 - 8 * r -: 8];
    for (int r = 0; r < 4; r++) begin
      m[r] = '0;
      for (int j = 0; j < 4; j++) begin
        m[r] = m[r] ^ aescbc_pkg::gmul(a[j], ctl.dec ? INV[(j - r + 4) & 3]
                                                     : FWD[(j - r + 4) & 3]);
      end
      mw[31 - 8 * r -: 8] = m[r];
    end
    if (ctl.dec) begin
      res = ctl.last ? aw : mw;
    end else begin
      res = (ctl.last ? aw : mw) ^ key;
    end
  end

endmodule

// ===== design/aescbc_key_step.sv =====
module aescbc_key_step (
  input  logic [127:0]      prev_key,
  input  aescbc_pkg::byte_t rcon,
  output logic [127:0]      next_key
);

  logic [31:0] t;
  logic [31:0] n0;
  logic [31:0] n1;
  logic [31:0] n2;
  logic [31:0] n3;

  always_comb begin
    t = {aescbc_pkg::SBOX[prev_key[23:16]] ^ rcon,
         aescbc_pkg::SBOX[prev_key[15:8]],
         aescbc_pkg::SBOX[prev_key[7:0]],
         aescbc_pkg::SBOX[prev_key[31:24]]};
    n0 = prev_key[127:96] ^ t;
    n1 = prev_key[95:64] ^ n0;
    n2 = prev_key[63:32] ^ n1;
    n3 = prev_key[31:0] ^ n2;
    next_key = {n0, n1, n2, n3};
  end

endmodule

// ===== design/aes128_cbc_block_cipher.sv =====
// Request: the block is loaded on accept, then ten rounds run; the last one writes the result.
// Requests: a new one is accepted only after the previous one has finished its final round.
// Stall: the final round holds while an earlier result waits to be taken.
// Key write or reset: round keys are expanded in turn, no request accepted meanwhile.
// Reset (rst, synchronous): key, IV and chain cleared, encrypt selected.
module aes128_cbc_block_cipher (
  input  logic                clk,
  input  logic                rst,
  aescbc_in_if.sink           blk_in,
  aescbc_out_if.source        blk_out,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data
);

  localparam logic [3:0] LAST = 4'(aescbc_pkg::NR);

  logic [63:0]  key_upper;
  logic [63:0]  key_lower;
  logic [63:0]  iv_upper;
  logic [63:0]  iv_lower;
  logic         dec;
  logic [127:0] chain;
  logic [127:0] rk [aescbc_pkg::NR + 1];
  logic [127:0] cur_key;
  logic [127:0] key_next;
  logic [127:0] new_key;
  logic         key_wr;
  logic         kbusy;
  logic [3:0]   kr;

  logic         run;
  logic [3:0]   rnd;
  logic [127:0] s;
  logic [127:0] preg;
  logic [127:0] cblk;
  logic [127:0] sh;
  logic [127:0] rnd_out;
  logic [127:0] rkey;
  logic [127:0] res;
  logic [127:0] blk;
  logic [127:0] prev;
  logic [127:0] out_data;
  logic         ov;
  logic         accept;
  logic         fin;
  aescbc_pkg::lane_ctl_t ctl;

  assign key_wr = cfg_we && (cfg_index == aescbc_pkg::REG_KEY_UPPER ||
                             cfg_index == aescbc_pkg::REG_KEY_LOWER);
  assign new_key = (cfg_index == aescbc_pkg::REG_KEY_UPPER) ? {cfg_data, key_lower}
                                                           : {key_upper, cfg_data};

  aescbc_key_step u_key_step (
    .prev_key (cur_key),
    .rcon     (aescbc_pkg::RCON[kr]),
    .next_key (key_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rk[0] <= '0;
      cur_key <= '0;
    end else if (key_wr) begin
      rk[0] <= new_key;
      cur_key <= new_key;
    end else if (kbusy) begin
      rk[kr] <= key_next;
      cur_key <= key_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_upper <= '0;
      key_lower <= '0;
      iv_upper <= '0;
      iv_lower <= '0;
      dec <= 1'b0;
      kbusy <= 1'b1;
      kr <= 4'd1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          aescbc_pkg::REG_KEY_UPPER: key_upper <= cfg_data;
          aescbc_pkg::REG_KEY_LOWER: key_lower <= cfg_data;
          aescbc_pkg::REG_IV_UPPER:  iv_upper <= cfg_data;
          aescbc_pkg::REG_IV_LOWER:  iv_lower <= cfg_data;
          aescbc_pkg::REG_DECRYPT:   dec <= cfg_data[0];
          default: ;
        endcase
      end
      if (key_wr) begin
        kbusy <= 1'b1;
        kr <= 4'd1;
      end else if (kbusy) begin
        if (kr == LAST) kbusy <= 1'b0;
        else kr <= kr + 4'd1;
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sh[127 - 8 * (r + 4 * c) -: 8] =
          s[127 - 8 * (r + 4 * (dec ? ((c - r + 4) & 3) : ((c + r) & 3))) -: 8];
      end
    end
  end

  assign rkey = rk[dec ? (LAST - rnd) : rnd];
  assign ctl = '{dec: dec, last: (rnd == LAST)};

  for (genvar c = 0; c < 4; c++) begin : g_lane
    aescbc_lane u_lane (
      .col (sh[127 - 32 * c -: 32]),
      .key (rkey[127 - 32 * c -: 32]),
      .ctl (ctl),
      .res (rnd_out[127 - 32 * c -: 32])
    );
  end

  assign res = dec ? (rnd_out ^ preg) : rnd_out;
  assign blk = {blk_in.block_upper, blk_in.block_lower};
  assign prev = blk_in.first_block ? {iv_upper, iv_lower} : chain;
  assign blk_in.ready = !run && !kbusy;
  assign accept = blk_in.valid && blk_in.ready;
  assign fin = run && (rnd == LAST) && (!ov || blk_out.ready);

  always_ff @(posedge clk) begin
    if (accept) begin
      s <= dec ? (blk ^ rk[aescbc_pkg::NR]) : (blk ^ prev ^ rk[0]);
      preg <= prev;
      cblk <= blk;
    end else if (run && rnd != LAST) begin
      s <= rnd_out;
    end
    if (fin) out_data <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      rnd <= '0;
      ov <= 1'b0;
      chain <= '0;
    end else begin
      if (accept) begin
        run <= 1'b1;
        rnd <= 4'd1;
      end else if (fin) begin
        run <= 1'b0;
        chain <= dec ? cblk : res;
      end else if (run && rnd != LAST) begin
        rnd <= rnd + 4'd1;
      end
      if (fin) ov <= 1'b1;
      else if (blk_out.ready) ov <= 1'b0;
    end
  end

  assign blk_out.valid = ov;
  assign blk_out.out_upper = out_data[127:64];
  assign blk_out.out_lower = out_data[63:0];

  a_fin_source: assert property (@(posedge clk) disable iff (rst)
    $rose(ov) |-> $past(run && rnd == LAST))
    else $error("result raised without a final round");
  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> run && rnd == 4'd1)
    else $error("accepted request did not start");
  a_no_keys_busy: assert property (@(posedge clk) disable iff (rst)
    accept |-> !kbusy)
    else $error("request accepted during key expansion");
  a_rnd_range: assert property (@(posedge clk) disable iff (rst)
    run |-> (rnd != 4'd0 && (rnd < LAST || rnd == LAST)))
    else $error("round counter out of range");

endmodule

// ===== tb/aes128_cbc_block_cipher_tb.sv =====
class cbc_scoreboard;
  logic [7:0]   sub_tab [256];
  logic [7:0]   inv_tab [256];
  logic [127:0] round_key [11];
  logic [127:0] key, iv, chain;
  bit           decrypt;
  logic [127:0] expected_q [$];
  int           errors;

  function new();
    logic [7:0] v;
    for (int x = 0; x < 256; x++) begin
      v = 8'h00;
      for (int y = 1; y < 256; y++) begin
        if (gf_mul(8'(x), 8'(y)) == 8'h01) v = 8'(y);
      end
      sub_tab[x] = v ^ rot8(v, 1) ^ rot8(v, 2) ^ rot8(v, 3) ^ rot8(v, 4) ^ 8'h63;
    end
    for (int x = 0; x < 256; x++) inv_tab[sub_tab[x]] = 8'(x);
    key = '0;
    iv = '0;
    chain = '0;
    decrypt = 0;
    errors = 0;
    expand_key();
  endfunction

  function logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (a[i]) r ^= b;
      b = b[7] ? ({b[6:0], 1'b0} ^ 8'h1b) : {b[6:0], 1'b0};
    end
    return r;
  endfunction

  function logic [7:0] rot8(logic [7:0] b, int n);
    return 8'((b << n) | (b >> (8 - n)));
  endfunction

  function void expand_key();
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    for (int i = 0; i < 4; i++) w[i] = key[127 - 32 * i -: 32];
    for (int i = 4; i < 44; i++) begin
      t = w[i - 1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {sub_tab[t[31:24]], sub_tab[t[23:16]], sub_tab[t[15:8]], sub_tab[t[7:0]]};
        t[31:24] ^= rc;
        rc = gf_mul(rc, 8'h02);
      end
      w[i] = w[i - 4] ^ t;
    end
    for (int r = 0; r < 11; r++) round_key[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
  endfunction

  function logic [7:0] byte_at(logic [127:0] s, int k);
    return s[127 - 8 * k -: 8];
  endfunction

  function logic [127:0] sub_bytes(logic [127:0] s, bit inv);
    logic [127:0] o;
    for (int k = 0; k < 16; k++) o[127 - 8 * k -: 8] = inv ? inv_tab[byte_at(s, k)] : sub_tab[byte_at(s, k)];
    return o;
  endfunction

  function logic [127:0] row_rotate(logic [127:0] s, bit inv);
    logic [127:0] o;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        o[127 - 8 * (r + 4 * c) -: 8] = byte_at(s, r + 4 * (inv ? ((c - r + 4) % 4) : ((c + r) % 4)));
    return o;
  endfunction

  function logic [127:0] col_mix(logic [127:0] s, bit inv);
    logic [7:0]   m [4];
    logic [7:0]   acc;
    logic [127:0] o;
    m = inv ? '{8'h0e, 8'h0b, 8'h0d, 8'h09} : '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int j = 0; j < 4; j++) acc ^= gf_mul(byte_at(s, 4 * c + j), m[(j - r + 4) % 4]);
        o[127 - 8 * (4 * c + r) -: 8] = acc;
      end
    return o;
  endfunction

  function logic [127:0] encipher(logic [127:0] s);
    s ^= round_key[0];
    for (int r = 1; r <= 10; r++) begin
      s = row_rotate(sub_bytes(s, 0), 0);
      if (r != 10) s = col_mix(s, 0);
      s ^= round_key[r];
    end
    return s;
  endfunction

  function logic [127:0] decipher(logic [127:0] s);
    s ^= round_key[10];
    for (int r = 9; r >= 0; r--) begin
      s = sub_bytes(row_rotate(s, 1), 1) ^ round_key[r];
      if (r != 0) s = col_mix(s, 1);
    end
    return s;
  endfunction

  function void write_reg(logic [2:0] idx, logic [63:0] data);
    case (idx)
      aescbc_pkg::REG_KEY_UPPER: begin key[127:64] = data; expand_key(); end
      aescbc_pkg::REG_KEY_LOWER: begin key[63:0] = data; expand_key(); end
      aescbc_pkg::REG_IV_UPPER:  iv[127:64] = data;
      aescbc_pkg::REG_IV_LOWER:  iv[63:0] = data;
      aescbc_pkg::REG_DECRYPT:   decrypt = data[0];
      default: ;
    endcase
  endfunction

  function void note_request(logic [63:0] upper, logic [63:0] lower, logic first);
    logic [127:0] prev, blk, res;
    prev = first ? iv : chain;
    blk = {upper, lower};
    if (decrypt) begin
      res = decipher(blk) ^ prev;
      chain = blk;
    end else begin
      res = encipher(blk ^ prev);
      chain = res;
    end
    expected_q.push_back(res);
  endfunction

  function void check_result(logic [63:0] upper, logic [63:0] lower);
    logic [127:0] want;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %h %h", upper, lower);
      return;
    end
    want = expected_q.pop_front();
    if (upper !== want[127:64] || lower !== want[63:0]) begin
      errors++;
      if (errors <= 10)
        $display("result mismatch: expected %h %h, got %h %h",
                 want[127:64], want[63:0], upper, lower);
    end
  endfunction
endclass

module aes128_cbc_block_cipher_tb;

  localparam logic [2:0] REG_SPARE = 3'd7;
  localparam int LIMIT = 400000;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  bit          idling = 1;
  int          cycles = 0;

  aescbc_in_if  blk_in ();
  aescbc_out_if blk_out ();
  cbc_scoreboard sb = new();

  aes128_cbc_block_cipher dut (
    .clk(clk), .rst(rst), .blk_in(blk_in.sink), .blk_out(blk_out.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    blk_in.valid = 0;
    blk_in.block_upper = '0;
    blk_in.block_lower = '0;
    blk_in.first_block = 0;
    blk_out.ready = 0;
  end

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("** aes128_cbc_block_cipher: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && blk_out.valid && blk_out.ready) sb.check_result(blk_out.out_upper, blk_out.out_lower);
    blk_out.ready <= rst ? 1'b0 : (!idling || $urandom_range(99) >= 28);
  end

  task automatic cfg_write(logic [2:0] idx, logic [63:0] data);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic send(logic [63:0] upper, logic [63:0] lower, logic first);
    if (idling && $urandom_range(99) < 28) begin
      blk_in.valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < 28) @(posedge clk);
    end
    blk_in.valid <= 1;
    blk_in.block_upper <= upper;
    blk_in.block_lower <= lower;
    blk_in.first_block <= first;
    do @(posedge clk); while (!blk_in.ready);
    sb.note_request(upper, lower, first);
  endtask

  task automatic stop_sending();
    blk_in.valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] rand_edge64();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return rand64();
    endcase
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send('0, '0, 0);
    send('1, '1, 0);
    send('0, '0, 1);
    stop_sending();
    drain();
    cfg_write(aescbc_pkg::REG_KEY_UPPER, 64'h0001020304050607);
    cfg_write(aescbc_pkg::REG_KEY_LOWER, 64'h08090a0b0c0d0e0f);
    send(64'h0011223344556677, 64'h8899aabbccddeeff, 1);
    send('1, '0, 0);
    send('0, '1, 0);
    stop_sending();
    drain();
    cfg_write(aescbc_pkg::REG_IV_UPPER, '1);
    cfg_write(aescbc_pkg::REG_IV_LOWER, 64'h0123456789abcdef);
    cfg_write(REG_SPARE, '1);
    send(64'h0011223344556677, 64'h8899aabbccddeeff, 1);
    send('1, '1, 0);
    stop_sending();
    drain();
    cfg_write(aescbc_pkg::REG_DECRYPT, 64'd1);
    send(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1);
    send('0, '0, 0);
    send('1, '1, 0);
    send(64'h0011223344556677, 64'h8899aabbccddeeff, 0);
    stop_sending();
    drain();
    cfg_write(aescbc_pkg::REG_DECRYPT, 64'd0);
    send('0, '1, 0);
    send(rand64(), rand64(), 0);

    for (int phase = 0; phase < 10; phase++) begin
      stop_sending();
      drain();
      idling = (phase != 4);
      cfg_write(aescbc_pkg::REG_KEY_UPPER, phase == 1 ? '1 : rand_edge64());
      cfg_write(aescbc_pkg::REG_KEY_LOWER, phase == 1 ? '1 : rand_edge64());
      cfg_write(aescbc_pkg::REG_IV_UPPER, rand_edge64());
      cfg_write(aescbc_pkg::REG_IV_LOWER, rand_edge64());
      cfg_write(aescbc_pkg::REG_DECRYPT, {rand64()} ^ (phase % 2));
      for (int n = 0; n < 82; n++) begin
        if (n == 40 && phase == 6) begin
          stop_sending();
          while (sb.expected_q.size() != 0) @(posedge clk);
        end
        send(rand64(), rand64(), $urandom_range(9) == 0);
      end
    end

    stop_sending();
    idling = 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** aes128_cbc_block_cipher: PASSED **");
    end else begin
      $display("** aes128_cbc_block_cipher: FAILED **");
    end
    $finish;
  end
endmodule
